>>> rtl/core/esd_pkg.sv
// shared types and constants for the escape sequence decoder
// used by esd_front, esd_queue, esd_back and the top level; no dependencies
`default_nettype none

package esd_pkg;

   // decode mode codes
   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_U0     = 3'd2;
   localparam logic [2:0] MODE_U3     = 3'd5;

   // character codes
   localparam logic [7:0] CHAR_BSL = 8'h5C;
   localparam logic [7:0] CHAR_N   = 8'h6E;
   localparam logic [7:0] CHAR_R   = 8'h72;
   localparam logic [7:0] CHAR_T   = 8'h74;
   localparam logic [7:0] CHAR_F   = 8'h66;
   localparam logic [7:0] CHAR_B   = 8'h62;
   localparam logic [7:0] CHAR_U   = 8'h75;

   // control bytes produced by the simple escapes
   localparam logic [7:0] CTRL_LF = 8'h0A;
   localparam logic [7:0] CTRL_CR = 8'h0D;
   localparam logic [7:0] CTRL_HT = 8'h09;
   localparam logic [7:0] CTRL_FF = 8'h0C;
   localparam logic [7:0] CTRL_BS = 8'h08;

   // utf-8 lead and continuation prefixes
   localparam logic [2:0] UTF8_LEAD2 = 3'b110;
   localparam logic [3:0] UTF8_LEAD3 = 4'b1110;
   localparam logic [1:0] UTF8_CONT  = 2'b10;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int CMD_BYTES   = 5;

   // one decoded burst: up to five result bytes from one request
   typedef struct packed {
      logic [CMD_BYTES-1:0][7:0] data;
      logic [2:0]                count;
      logic                      done;
   } esd_cmd_type;

   // hex digit check: bit 4 valid, bits 3:0 value
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/esd_front.sv
// front part: accepts request bytes, tracks the escape state and builds bursts
// depends on esd_pkg
`default_nettype none

module esd_front
   import esd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [7:0]  in_byte,
   input  wire logic        in_end,
   input  wire logic        queue_full,
   output      logic        in_ready,
   output      logic        push,
   output      esd_cmd_type push_cmd
);

   logic [2:0]      mode_ff, mode_in;
   logic [2:0][7:0] held_ff, held_in;
   logic [11:0]     accum_ff, accum_in;

   logic            fire;
   logic            is_u;
   logic [1:0]      held;
   logic [4:0]      hexv;
   logic [2:0][7:0] digits;
   logic [3:0][7:0] flush;
   logic [15:0]     cp;
   esd_cmd_type     cmd;

   assign in_ready = !queue_full;
   assign fire     = in_valid && !queue_full;
   assign is_u     = (mode_ff >= MODE_U0) && (mode_ff <= MODE_U3);
   assign held     = 2'(mode_ff - MODE_U0);
   assign hexv     = hex_value(in_byte);
   assign cp       = {accum_ff, hexv[3:0]};

   // held digits with the incoming one placed at its slot
   always_comb begin
      digits = held_ff;
      if (hexv[4] && held != 2'd3) begin
         digits[held] = in_byte;
      end
      flush = {digits[2], digits[1], digits[0], CHAR_U};
   end

   // decode one request into a burst and the next escape state
   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      accum_in  = accum_ff;
      cmd.data  = '0;
      cmd.count = 3'd0;
      cmd.done  = in_end;
      if (mode_ff == MODE_ESC) begin
         mode_in   = MODE_NORMAL;
         cmd.count = 3'd1;
         unique case (in_byte)
            CHAR_N:  cmd.data[0] = CTRL_LF;
            CHAR_R:  cmd.data[0] = CTRL_CR;
            CHAR_T:  cmd.data[0] = CTRL_HT;
            CHAR_F:  cmd.data[0] = CTRL_FF;
            CHAR_B:  cmd.data[0] = CTRL_BS;
            CHAR_U: begin
               mode_in     = MODE_U0;
               accum_in    = '0;
               cmd.data[0] = CHAR_U;
               cmd.count   = in_end ? 3'd1 : 3'd0;
            end
            default: cmd.data[0] = in_byte;
         endcase
      end else if (is_u) begin
         if (!hexv[4]) begin
            // bad digit: flush literally, then handle the byte as in normal mode
            cmd.data[3:0] = flush;
            cmd.count     = 3'd1 + {1'b0, held};
            mode_in       = MODE_NORMAL;
            if (in_byte == CHAR_BSL) begin
               mode_in = MODE_ESC;
            end else begin
               for (int k = 0; k < CMD_BYTES; k++) begin
                  if (3'(k) == 3'd1 + {1'b0, held}) begin
                     cmd.data[k] = in_byte;
                  end
               end
               cmd.count = 3'd2 + {1'b0, held};
            end
         end else if (held != 2'd3) begin
            held_in  = digits;
            accum_in = {accum_ff[7:0], hexv[3:0]};
            mode_in  = mode_ff + 3'd1;
            if (in_end) begin
               cmd.data[3:0] = flush;
               cmd.count     = 3'd2 + {1'b0, held};
            end
         end else begin
            // fourth digit: utf-8 encode the code point
            mode_in = MODE_NORMAL;
            if (cp[15:7] == '0) begin
               cmd.data[0] = {1'b0, cp[6:0]};
               cmd.count   = 3'd1;
            end else if (cp[15:11] == '0) begin
               cmd.data[0] = {UTF8_LEAD2, cp[10:6]};
               cmd.data[1] = {UTF8_CONT, cp[5:0]};
               cmd.count   = 3'd2;
            end else begin
               cmd.data[0] = {UTF8_LEAD3, cp[15:12]};
               cmd.data[1] = {UTF8_CONT, cp[11:6]};
               cmd.data[2] = {UTF8_CONT, cp[5:0]};
               cmd.count   = 3'd3;
            end
         end
      end else begin
         mode_in = MODE_NORMAL;
         if (in_byte == CHAR_BSL) begin
            mode_in = MODE_ESC;
         end else begin
            cmd.data[0] = in_byte;
            cmd.count   = 3'd1;
         end
      end
      if (in_end) begin
         mode_in = MODE_NORMAL;
      end
   end

   assign push     = fire && (cmd.count != 3'd0);
   assign push_cmd = cmd;

   // escape state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         accum_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
      end
   end

   // held digit bytes, no reset needed
   always_ff @(posedge clock) begin
      if (fire) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/esd_queue.sv
// short queue of decoded bursts between front and back
// depends on esd_pkg
`default_nettype none

module esd_queue
   import esd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire esd_cmd_type push_cmd,
   input  wire logic        pop,
   output      logic        full,
   output      logic        empty,
   output      esd_cmd_type head
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   esd_cmd_type         mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // burst storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/esd_back.sv
// back part: plays out the bytes of the head burst one per cycle while out_ready is high
// depends on esd_pkg
`default_nettype none

module esd_back
   import esd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        empty,
   input  wire esd_cmd_type head,
   input  wire logic        out_ready,
   output      logic        out_valid,
   output      logic [7:0]  out_byte,
   output      logic        out_last,
   output      logic        out_done,
   output      logic        pop
);

   logic [2:0] idx_ff, idx_in;
   logic       fire;

   assign out_valid = !empty;
   assign out_byte  = head.data[idx_ff];
   assign out_last  = (idx_ff == head.count - 3'd1);
   assign out_done  = out_last && head.done;
   assign fire      = out_valid && out_ready;
   assign pop       = fire && out_last;

   // byte index within the head burst
   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = out_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/escape_sequence_decoder.sv
// top level of the backslash escape decoder with utf-8 output
// depends on esd_pkg, esd_front, esd_queue and esd_back
//
// usage:
// - request channel (req_*): one raw byte per request in req_tdata, req_tlast
//   marks the last byte of a string
// - response channel (rsp_*): one decoded byte per response, rsp_tlast marks
//   the final byte caused by one request, rsp_tuser the final byte of the string
// - a request that yields no byte (a backslash, digits of a \u) gives no response
// - a byte accepted on req is written into the registered burst queue and offered on rsp from its head
// - throughput: one request per cycle while each yields at most one byte and
//   rsp_tready stays high; a request yielding n bytes holds the response side
//   until all n are taken, as the back part has a single byte-per-cycle port
// - a two-entry burst queue parts the sides, so requests keep flowing while
//   a response waits; once both entries are held, req_tready drops
// - when the receiver stalls, the offered byte holds until taken
// - reset clears the escape state and empties the queue; no clearing pass
`default_nettype none

module escape_sequence_decoder
   import esd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // end_of_string
   // response channel
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] out_byte
   output      logic       rsp_tlast,   // last_of_run
   output      logic       rsp_tuser    // [0] string_done
);

   logic        push, pop, full, empty;
   esd_cmd_type push_cmd, head;

   esd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .queue_full (full),
      .in_ready   (req_tready),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   esd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   esd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_done  (rsp_tuser),
      .pop       (pop)
   );

endmodule

`default_nettype wire
